[rtl/bbps_pkg.sv]
// bbps_pkg: types, constants and helper functions for the ball bounce physics step unit.
// Used by bbps_ctrl, bbps_dp, ball_bounce_physics_step_unit and bbps_checker.
`timescale 1ns / 1ps
package bbps_pkg;

    typedef enum logic [2:0] {
        REG_GRAVITY     = 3'd0,
        REG_AIR         = 3'd1,
        REG_GND_REST    = 3'd2,
        REG_WALL_REST   = 3'd3,
        REG_RADIUS      = 3'd4,
        REG_HALF_WIDTH  = 3'd5,
        REG_HEIGHT      = 3'd6,
        REG_NET_HEIGHT  = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_HIT   = 2'd1,
        FUNC_PLACE = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        STEP_GRAV   = 4'd0,
        STEP_DX     = 4'd1,
        STEP_DY     = 4'd2,
        STEP_K      = 4'd3,
        STEP_DRAG_X = 4'd4,
        STEP_DRAG_Y = 4'd5,
        STEP_GROUND = 4'd6,
        STEP_WALL_R = 4'd7,
        STEP_WALL_L = 4'd8,
        STEP_CEIL   = 4'd9,
        STEP_NET    = 4'd10
    } step_t;

    typedef struct packed {
        logic signed [23:0] gravity;
        logic [15:0]        air;
        logic [15:0]        gnd_rest;
        logic [15:0]        wall_rest;
        logic [15:0]        radius;
        logic [22:0]        half_width;
        logic [22:0]        height;
        logic [22:0]        net_height;
    } cfg_t;

    typedef struct packed {
        func_t              func;
        logic [15:0]        delta_time;
        logic               serving;
        logic               paused;
        logic signed [31:0] hit_vel_x;
        logic signed [31:0] hit_vel_y;
        logic signed [31:0] player_x;
        logic               player_facing;
        logic               player_side;
    } item_t;

    typedef struct packed {
        logic signed [31:0] ball_x;
        logic signed [31:0] ball_y;
        logic signed [31:0] ball_vx;
        logic signed [31:0] ball_vy;
        logic               court_side;
        logic               hit_ground;
        logic               hit_wall;
        logic               hit_net;
        logic               changed_side;
        logic               racket_event;
    } res_t;

    typedef struct packed {
        logic  load;
        logic  start;
        logic  mul;
        logic  apply;
        logic  out_load;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic tick;
    } sts_t;

    localparam logic signed [31:0] TENTH_Q  = 32'sd6554;
    localparam logic signed [31:0] PLACE_Y  = 32'sd117965;
    localparam logic signed [31:0] PLACE_VY = 32'sd262144;
    localparam logic signed [31:0] Q_ONE    = 32'sd65536;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -40'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // round to nearest, ties up, dropping 16 fraction bits
    function automatic logic signed [35:0] rnd16(input logic signed [51:0] p);
        logic signed [51:0] t;
        t = p + 52'sd32768;
        return t[51:16];
    endfunction

    function automatic logic signed [34:0] rnd17(input logic signed [51:0] p);
        logic signed [51:0] t;
        t = p + 52'sd65536;
        return t[51:17];
    endfunction

endpackage

[rtl/bbps_ctrl.sv]
// bbps_ctrl: sequencer for the physics step, issues commands to bbps_dp.
// Depends on bbps_pkg.
`timescale 1ns / 1ps
module bbps_ctrl
    import bbps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_APPLY = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.step       = step_reg;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.start = 1'b1;
                if (sts.tick)
                begin
                    step_next  = STEP_GRAV;
                    state_next = ST_MUL;
                end
                else
                    state_next = ST_DONE;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply = 1'b1;
                if (step_reg == STEP_NET)
                    state_next = ST_DONE;
                else
                begin
                    step_next  = step_t'(step_reg + 4'd1);
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_GRAV;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/bbps_dp.sv]
// bbps_dp: ball state, shared multiplier and the update logic of each step.
// Depends on bbps_pkg; driven by bbps_ctrl.
`timescale 1ns / 1ps
module bbps_dp
    import bbps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  item_t item,
    input  cmd_t  cmd,
    output sts_t  sts,
    output res_t  res
);

    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [31:0] vx_reg, vx_next, vy_reg, vy_next;
    logic               side_reg, side_next;
    logic signed [31:0] vy0_reg, vy0_next;
    logic [16:0]        k_reg, k_next;
    logic signed [51:0] prod_reg, prod_next;
    item_t              item_reg, item_next;
    logic               fg_reg, fg_next, fw_reg, fw_next, fn_reg, fn_next;
    logic               fc_reg, fc_next, fr_reg, fr_next;
    res_t               res_reg, res_next;

    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] r16;
    logic signed [34:0] r17;
    logic signed [31:0] bnc;
    logic signed [32:0] wall_lim, ceil_lim, diff;
    logic signed [31:0] radius_s;
    logic               nside, let_ball, net_hit;

    assign sts.tick = (item_reg.func == FUNC_TICK) && !item_reg.paused;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            STEP_GRAV:
            begin
                mul_a = 34'(cfg.gravity);
                mul_b = {2'b00, item_reg.delta_time};
            end
            STEP_DX:
            begin
                mul_a = {vx_reg[31], vx_reg, 1'b0};
                mul_b = {2'b00, item_reg.delta_time};
            end
            STEP_DY:
            begin
                mul_a = 34'(vy0_reg) + 34'(vy_reg);
                mul_b = {2'b00, item_reg.delta_time};
            end
            STEP_K:
            begin
                mul_a = {18'd0, cfg.air};
                mul_b = {2'b00, item_reg.delta_time};
            end
            STEP_DRAG_X:
            begin
                mul_a = 34'(vx_reg);
                mul_b = {1'b0, k_reg};
            end
            STEP_DRAG_Y:
            begin
                mul_a = 34'(vy_reg);
                mul_b = {1'b0, k_reg};
            end
            STEP_GROUND:
            begin
                mul_a = 34'(vy_reg);
                mul_b = {2'b00, cfg.gnd_rest};
            end
            STEP_WALL_R, STEP_WALL_L:
            begin
                mul_a = 34'(vx_reg);
                mul_b = {2'b00, cfg.wall_rest};
            end
            STEP_CEIL:
            begin
                mul_a = 34'(vy_reg);
                mul_b = {2'b00, cfg.wall_rest};
            end
            STEP_NET:
            begin
                mul_a = 34'(vx_reg);
                mul_b = {2'b00, TENTH_Q[15:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign r16      = rnd16(prod_reg);
    assign r17      = rnd17(prod_reg);
    assign bnc      = sat32(-(40'(r16)));
    assign radius_s = {16'd0, cfg.radius};
    assign wall_lim = $signed({10'd0, cfg.half_width}) - $signed({17'd0, cfg.radius});
    assign ceil_lim = $signed({10'd0, cfg.height}) - $signed({17'd0, cfg.radius});
    assign diff     = 33'(py_reg) - $signed({10'd0, cfg.net_height});
    assign nside    = !px_reg[31];
    assign let_ball = (diff < 33'sd6554) && (diff > -33'sd6554) && !item_reg.serving
                      && vy_reg[31];
    assign net_hit  = diff[32] && !let_ball;

    always_comb
    begin
        px_next   = px_reg;
        py_next   = py_reg;
        vx_next   = vx_reg;
        vy_next   = vy_reg;
        side_next = side_reg;
        vy0_next  = vy0_reg;
        k_next    = k_reg;
        prod_next = prod_reg;
        item_next = item_reg;
        fg_next   = fg_reg;
        fw_next   = fw_reg;
        fn_next   = fn_reg;
        fc_next   = fc_reg;
        fr_next   = fr_reg;
        res_next  = res_reg;

        if (cmd.load)
        begin
            item_next = item;
            fg_next   = 1'b0;
            fw_next   = 1'b0;
            fn_next   = 1'b0;
            fc_next   = 1'b0;
            fr_next   = 1'b0;
        end

        if (cmd.start)
        begin
            vy0_next = vy_reg;
            case (item_reg.func)
                FUNC_HIT:
                begin
                    vx_next = item_reg.hit_vel_x;
                    vy_next = item_reg.hit_vel_y;
                    fr_next = 1'b1;
                end
                FUNC_PLACE:
                begin
                    px_next   = sat32(40'(item_reg.player_x) +
                                (item_reg.player_facing ? 40'sd6554 : -40'sd6554));
                    py_next   = PLACE_Y;
                    side_next = item_reg.player_side;
                    vx_next   = item_reg.player_facing ? -Q_ONE : Q_ONE;
                    vy_next   = PLACE_VY;
                end
                default:
                    ;
            endcase
        end

        if (cmd.mul)
            prod_next = mul_a * mul_b;

        if (cmd.apply)
        begin
            case (cmd.step)
                STEP_GRAV:
                    vy_next = sat32(40'(vy_reg) + 40'(r16));
                STEP_DX:
                    px_next = sat32(40'(px_reg) + 40'(r17));
                STEP_DY:
                    py_next = sat32(40'(py_reg) + 40'(r17));
                STEP_K:
                    k_next = r16[16:0];
                STEP_DRAG_X:
                    vx_next = sat32(40'(vx_reg) - 40'(r16));
                STEP_DRAG_Y:
                    vy_next = sat32(40'(vy_reg) - 40'(r16));
                STEP_GROUND:
                    if (py_reg < radius_s)
                    begin
                        py_next = radius_s;
                        vy_next = bnc;
                        fg_next = 1'b1;
                    end
                STEP_WALL_R:
                    if (33'(px_reg) > wall_lim)
                    begin
                        px_next = wall_lim[31:0];
                        vx_next = bnc;
                        fw_next = 1'b1;
                    end
                STEP_WALL_L:
                    if (33'(px_reg) < -wall_lim)
                    begin
                        px_next = 32'(-wall_lim);
                        vx_next = bnc;
                        fw_next = 1'b1;
                    end
                STEP_CEIL:
                    if (33'(py_reg) > ceil_lim)
                    begin
                        py_next = ceil_lim[31:0];
                        vy_next = bnc;
                    end
                STEP_NET:
                    if (nside != side_reg)
                    begin
                        if (net_hit)
                        begin
                            vx_next = bnc;
                            px_next = '0;
                            fn_next = 1'b1;
                        end
                        else
                        begin
                            // let: ball skims the net top, falling
                            if (let_ball)
                                vy_next = sat32(-(40'(vy_reg)));
                            side_next = nside;
                            fc_next   = 1'b1;
                        end
                    end
                default:
                    ;
            endcase
        end

        if (cmd.out_load)
        begin
            res_next.ball_x       = px_reg;
            res_next.ball_y       = py_reg;
            res_next.ball_vx      = vx_reg;
            res_next.ball_vy      = vy_reg;
            res_next.court_side   = side_reg;
            res_next.hit_ground   = fg_reg;
            res_next.hit_wall     = fw_reg;
            res_next.hit_net      = fn_reg;
            res_next.changed_side = fc_reg;
            res_next.racket_event = fr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg   <= '0;
            py_reg   <= '0;
            vx_reg   <= '0;
            vy_reg   <= '0;
            side_reg <= 1'b0;
        end
        else
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            vx_reg   <= vx_next;
            vy_reg   <= vy_next;
            side_reg <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vy0_reg  <= vy0_next;
        k_reg    <= k_next;
        prod_reg <= prod_next;
        item_reg <= item_next;
        fg_reg   <= fg_next;
        fw_reg   <= fw_next;
        fn_reg   <= fn_next;
        fc_reg   <= fc_next;
        fr_reg   <= fr_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

[rtl/ball_bounce_physics_step_unit.sv]
// ball_bounce_physics_step_unit: a tick goes from the accepted beat through a start
// state, eleven multiply/apply pairs on the one shared 34x18 multiplier and an output
// load to the result beat. Racket, place, paused-tick and no-op beats go from the start
// state to the output load, which waits while an earlier result is unaccepted. One item
// is worked on at a time; a result waiting in the output register does not block the
// next input beat. rst_n clears the ball state to zero and the config registers to
// their defaults.
`timescale 1ns / 1ps
module ball_bounce_physics_step_unit
    import bbps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [23:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // delta_time, serving, paused, hit_vel_x, hit_vel_y, player_x, player_facing,
    // player_side, zero fill
    input  logic [119:0] s_axis_tdata,
    // func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // ball_x, ball_y, ball_vx, ball_vy, court_side, hit_ground, hit_wall, hit_net,
    // changed_side, racket_event, zero fill
    output logic [135:0] m_axis_tdata
);

    cfg_t  cfg_reg, cfg_next;
    item_t item;
    cmd_t  cmd;
    sts_t  sts;
    res_t  res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_GRAVITY:    cfg_next.gravity    = cfg_wdata;
                REG_AIR:        cfg_next.air        = cfg_wdata[15:0];
                REG_GND_REST:   cfg_next.gnd_rest   = cfg_wdata[15:0];
                REG_WALL_REST:  cfg_next.wall_rest  = cfg_wdata[15:0];
                REG_RADIUS:     cfg_next.radius     = cfg_wdata[15:0];
                REG_HALF_WIDTH: cfg_next.half_width = cfg_wdata[22:0];
                REG_HEIGHT:     cfg_next.height     = cfg_wdata[22:0];
                REG_NET_HEIGHT: cfg_next.net_height = cfg_wdata[22:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gravity    <= -24'sd589824;
            cfg_reg.air        <= 16'd39322;
            cfg_reg.gnd_rest   <= 16'd39322;
            cfg_reg.wall_rest  <= 16'd39322;
            cfg_reg.radius     <= 16'd6554;
            cfg_reg.half_width <= 23'd262144;
            cfg_reg.height     <= 23'd262144;
            cfg_reg.net_height <= 23'd65536;
        end
        else
            cfg_reg <= cfg_next;
    end

    assign item.func          = func_t'(s_axis_tuser);
    assign item.delta_time    = s_axis_tdata[15:0];
    assign item.serving       = s_axis_tdata[16];
    assign item.paused        = s_axis_tdata[17];
    assign item.hit_vel_x     = s_axis_tdata[49:18];
    assign item.hit_vel_y     = s_axis_tdata[81:50];
    assign item.player_x      = s_axis_tdata[113:82];
    assign item.player_facing = s_axis_tdata[114];
    assign item.player_side   = s_axis_tdata[115];

    bbps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bbps_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .item  (item),
        .cmd   (cmd),
        .sts   (sts),
        .res   (res)
    );

    assign m_axis_tdata = {2'b00, res.racket_event, res.changed_side, res.hit_net,
                           res.hit_wall, res.hit_ground, res.court_side, res.ball_vy,
                           res.ball_vx, res.ball_y, res.ball_x};

endmodule

[rtl/bbps_checker.sv]
// bbps_checker: port-level assertions for ball_bounce_physics_step_unit, bound below.
// Depends on bbps_pkg only for the shared import style.
`timescale 1ns / 1ps
module bbps_checker
    import bbps_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata
);

    logic [4:0] flags;
    assign flags = m_axis_tdata[133:129];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // one item in flight: busy right after a beat is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

    a_racket_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && flags[4] |-> flags[3:0] == 4'd0)
        else $error("racket result carries tick flags");

    a_net_or_cross: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(flags[2] && flags[3]))
        else $error("net strike and side change in one tick");

endmodule

bind ball_bounce_physics_step_unit bbps_checker u_bbps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[bench/ball_bounce_physics_step_unit_test.sv]
// Self-checking bench for ball_bounce_physics_step_unit: directed and random items, with
// random stalls on both stream sides, compared against an in-bench fixed-point ball model.
// Depends on bbps_pkg and the unit's RTL.
`timescale 1ns / 1ps
module ball_bounce_physics_step_unit_test;
    import bbps_pkg::*;

    class ball_scoreboard;
        logic signed [31:0] bx, by, bvx, bvy;
        bit                 bside;
        longint             grav, drag, keep_gnd, keep_wall, radius, half_w, height, net_top;
        res_t               expected_results[$];
        int                 errors;

        function new();
            bx = 0; by = 0; bvx = 0; bvy = 0; bside = 0;
            grav = -589824; drag = 39322; keep_gnd = 39322; keep_wall = 39322;
            radius = 6554; half_w = 262144; height = 262144; net_top = 65536;
            errors = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [23:0] d);
            case (idx)
                REG_GRAVITY:    grav = longint'(signed'(d));
                REG_AIR:        drag = d[15:0];
                REG_GND_REST:   keep_gnd = d[15:0];
                REG_WALL_REST:  keep_wall = d[15:0];
                REG_RADIUS:     radius = d[15:0];
                REG_HALF_WIDTH: half_w = d[22:0];
                REG_HEIGHT:     height = d[22:0];
                REG_NET_HEIGHT: net_top = d[22:0];
                default: ;
            endcase
        endfunction

        // round to nearest, ties up
        function longint rnd(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function logic signed [31:0] clamp(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        endfunction

        function logic signed [31:0] rebound(logic signed [31:0] v, longint keep);
            return clamp(-rnd(longint'(v) * keep, 16));
        endfunction

        function void note_item(item_t it);
            res_t r;
            logic signed [31:0] vx0, vy0, vx1, vy1;
            longint dt, k, lim, diff;
            bit nside, let_ball;
            r = '0;
            dt = it.delta_time;
            if (it.func == FUNC_TICK && !it.paused)
            begin
                vx0 = bvx;
                vy0 = bvy;
                vx1 = vx0;
                vy1 = clamp(longint'(vy0) + rnd(grav * dt, 16));
                bx = clamp(longint'(bx) + rnd((longint'(vx0) + longint'(vx1)) * dt, 17));
                by = clamp(longint'(by) + rnd((longint'(vy0) + longint'(vy1)) * dt, 17));
                k = rnd(drag * dt, 16);
                bvx = clamp(longint'(vx1) - rnd(k * longint'(vx1), 16));
                bvy = clamp(longint'(vy1) - rnd(k * longint'(vy1), 16));
                if (longint'(by) < radius)
                begin
                    by = radius[31:0];
                    bvy = rebound(bvy, keep_gnd);
                    r.hit_ground = 1;
                end
                lim = half_w - radius;
                if (longint'(bx) > lim)
                begin
                    bx = clamp(lim);
                    bvx = rebound(bvx, keep_wall);
                    r.hit_wall = 1;
                end
                if (longint'(bx) < -lim)
                begin
                    bx = clamp(-lim);
                    bvx = rebound(bvx, keep_wall);
                    r.hit_wall = 1;
                end
                lim = height - radius;
                if (longint'(by) > lim)
                begin
                    by = clamp(lim);
                    bvy = rebound(bvy, keep_wall);
                end
                nside = (bx < 0) ? 1'b0 : 1'b1;
                if (nside != bside)
                begin
                    diff = longint'(by) - net_top;
                    let_ball = diff < 6554 && diff > -6554 && !it.serving && bvy < 0;
                    if (diff < 0 && !let_ball)
                    begin
                        bvx = rebound(bvx, 6554);
                        bx = 0;
                        nside = bside;
                        r.hit_net = 1;
                    end
                    else
                    begin
                        if (let_ball)
                            bvy = clamp(-longint'(bvy));
                        r.changed_side = 1;
                    end
                end
                bside = nside;
            end
            else if (it.func == FUNC_HIT)
            begin
                bvx = it.hit_vel_x;
                bvy = it.hit_vel_y;
                r.racket_event = 1;
            end
            else if (it.func == FUNC_PLACE)
            begin
                bx = clamp(longint'(it.player_x) + (it.player_facing ? 6554 : -6554));
                by = PLACE_Y;
                bside = it.player_side;
                bvx = it.player_facing ? -Q_ONE : Q_ONE;
                bvy = PLACE_VY;
            end
            r.ball_x = bx;
            r.ball_y = by;
            r.ball_vx = bvx;
            r.ball_vy = bvy;
            r.court_side = bside;
            expected_results.push_back(r);
        endfunction

        function void field(string name, longint e, longint a);
            if (e != a)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
            end
        endfunction

        function void check_result(res_t a);
            res_t e;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, actual %h", $time, a);
                return;
            end
            e = expected_results.pop_front();
            field("ball_x", e.ball_x, a.ball_x);
            field("ball_y", e.ball_y, a.ball_y);
            field("ball_vx", e.ball_vx, a.ball_vx);
            field("ball_vy", e.ball_vy, a.ball_vy);
            field("court_side", e.court_side, a.court_side);
            field("hit_ground", e.hit_ground, a.hit_ground);
            field("hit_wall", e.hit_wall, a.hit_wall);
            field("hit_net", e.hit_net, a.hit_net);
            field("changed_side", e.changed_side, a.changed_side);
            field("racket_event", e.racket_event, a.racket_event);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [2:0]   cfg_addr;
    logic [23:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;

    ball_scoreboard ball_sb = new();
    bit send_idle = 1;
    bit recv_idle = 1;
    bit long_hold = 0;

    ball_bounce_physics_step_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // result checked before the new input is noted, both at the same edge
    always @(posedge clk)
    begin
        item_t it;
        res_t  r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            r = '0;
            r.ball_x = m_axis_tdata[31:0];
            r.ball_y = m_axis_tdata[63:32];
            r.ball_vx = m_axis_tdata[95:64];
            r.ball_vy = m_axis_tdata[127:96];
            {r.racket_event, r.changed_side, r.hit_net, r.hit_wall, r.hit_ground,
             r.court_side} = m_axis_tdata[133:128];
            ball_sb.check_result(r);
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            it.func = func_t'(s_axis_tuser);
            it.delta_time = s_axis_tdata[15:0];
            it.serving = s_axis_tdata[16];
            it.paused = s_axis_tdata[17];
            it.hit_vel_x = s_axis_tdata[49:18];
            it.hit_vel_y = s_axis_tdata[81:50];
            it.player_x = s_axis_tdata[113:82];
            it.player_facing = s_axis_tdata[114];
            it.player_side = s_axis_tdata[115];
            ball_sb.note_item(it);
        end
    end

    // result side: random stalls per beat, one long hold when asked
    initial
    begin
        int n;
        m_axis_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = recv_idle ? $urandom_range(0, 6) : 0;
            if (long_hold)
            begin
                n = 400;
                long_hold = 0;
            end
            if (n > 0)
            begin
                m_axis_tready = 0;
                repeat (n) @(negedge clk);
            end
            m_axis_tready = 1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    task automatic send(logic [1:0] fn, logic [15:0] dt, bit serv, bit pause,
                        logic [31:0] hvx, logic [31:0] hvy, logic [31:0] plx,
                        bit facing, bit pside);
        int gap;
        bit ok;
        gap = send_idle ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tuser = fn;
        s_axis_tdata = {4'b0, pside, facing, plx, hvy, hvx, pause, serv, dt};
        s_axis_tvalid = 1;
        do
        begin
            ok = s_axis_tready;
            @(posedge clk);
        end
        while (!ok);
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 0;
        while (ball_sb.expected_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_cfg(cfg_idx_t idx, logic [23:0] d);
        @(negedge clk);
        cfg_wr_en = 1;
        cfg_addr = idx;
        cfg_wdata = d;
        ball_sb.write_reg(idx, d);
        @(negedge clk);
        cfg_wr_en = 0;
    endtask

    task automatic load_cfg(logic [23:0] g, logic [15:0] a, logic [15:0] gr,
                            logic [15:0] wr, logic [15:0] rad, logic [22:0] hw,
                            logic [22:0] ht, logic [22:0] nt);
        write_cfg(REG_GRAVITY, g);
        write_cfg(REG_AIR, a);
        write_cfg(REG_GND_REST, gr);
        write_cfg(REG_WALL_REST, wr);
        write_cfg(REG_RADIUS, rad);
        write_cfg(REG_HALF_WIDTH, hw);
        write_cfg(REG_HEIGHT, ht);
        write_cfg(REG_NET_HEIGHT, nt);
    endtask

    task automatic random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            send(FUNC_TICK, $urandom_range(0, 8000), $urandom_range(0, 1),
                 $urandom_range(0, 19) == 0, $urandom, $urandom, $urandom, 0, 0);
        else if (sel < 80)
            send(FUNC_HIT, $urandom, 0, 0, $urandom_range(0, 16 << 16) - (8 << 16),
                 $urandom_range(0, 16 << 16) - (8 << 16), $urandom, 0, 0);
        else if (sel < 90)
            send(FUNC_PLACE, $urandom, 0, 0, $urandom, $urandom,
                 $urandom_range(0, 8 << 16) - (4 << 16), $urandom_range(0, 1),
                 $urandom_range(0, 1));
        else
            send($urandom_range(0, 3), $urandom, $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom, $urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    initial
    begin
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed items on reset settings
        send(FUNC_PLACE, 0, 0, 0, 0, 0, 0, 1, 0);
        send(FUNC_TICK, 6554, 0, 0, 0, 0, 0, 0, 0);
        send(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        send(FUNC_TICK, 65535, 0, 0, 0, 0, 0, 0, 0);
        send(FUNC_TICK, 65535, 1, 1, 0, 0, 0, 0, 0);
        send(FUNC_NONE, 65535, 1, 1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 1);
        send(FUNC_HIT, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0);
        send(FUNC_TICK, 65535, 0, 0, 0, 0, 0, 0, 0);
        send(FUNC_HIT, 0, 0, 0, 32'h80000000, 32'h7fffffff, 0, 0, 0);
        send(FUNC_TICK, 65535, 0, 0, 0, 0, 0, 0, 0);
        send(FUNC_PLACE, 0, 0, 0, 0, 0, 32'h7fffffff, 1, 1);
        send(FUNC_PLACE, 0, 0, 0, 0, 0, 32'h80000000, 0, 0);
        send(FUNC_TICK, 6554, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // let and net strike: net top at the place height, ball crossing just below it
        write_cfg(REG_NET_HEIGHT, 117965);
        send(FUNC_PLACE, 0, 0, 0, 0, 0, -13107, 1, 0);
        send(FUNC_HIT, 0, 0, 0, 131072, -6554, 0, 0, 0);
        send(FUNC_TICK, 6554, 0, 0, 0, 0, 0, 0, 0);
        send(FUNC_PLACE, 0, 0, 0, 0, 0, -13107, 1, 0);
        send(FUNC_HIT, 0, 0, 0, 131072, -6554, 0, 0, 0);
        send(FUNC_TICK, 6554, 1, 0, 0, 0, 0, 0, 0);
        send(FUNC_PLACE, 0, 0, 0, 0, 0, 13107, 0, 1);
        send(FUNC_TICK, 6554, 0, 0, 0, 0, 0, 0, 0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: load_cfg(-589824, 39322, 39322, 39322, 6554, 262144, 262144, 65536);
                1: load_cfg(24'h800000, 65535, 0, 65535, 65535, 0, 0, 0);
                2: load_cfg(24'h7fffff, 0, 65535, 0, 0, 23'h7fffff, 23'h7fffff, 23'h7fffff);
                3: load_cfg(-589824, 39322, 39322, 39322, 40000, 30000, 20000, 65536);
                default: load_cfg(-$urandom_range(0, 20 << 16), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom_range(0, 20000), $urandom_range(65536, 8 << 16),
                                  $urandom_range(65536, 8 << 16), $urandom_range(0, 3 << 16));
            endcase
            send_idle = (phase % 3) != 1;
            recv_idle = (phase % 4) != 2;
            if (phase == 4)
                long_hold = 1;
            for (int i = 0; i < 100; i++)
            begin
                if (phase == 5 && i == 50)
                    drain();
                random_item();
            end
            drain();
        end

        if (ball_sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
